FILE: src/fps_pkg.sv
// shared types and constants of the frame parser with additive checksum
`timescale 1ns / 1ps

package fps_pkg;

  localparam int ByteW      = 8;
  localparam int LenW       = 7;
  localparam int AddrW      = 6;
  localparam int StoreDepth = 64;
  localparam int TdataW     = 32;

  localparam logic [LenW-1:0]  MaxPayload     = 7'd64;
  localparam logic [ByteW-1:0] StartByteReset = 8'd126;

  typedef struct packed {
    logic cap_start;
    logic cap_type;
    logic cap_len_lo;
    logic cap_len_hi;
    logic cap_data;
    logic emit_start;
    logic rd_issue;
    logic rd_next;
    logic out_load_data;
    logic out_load_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_match;
    logic len_too_big;
    logic in_len_zero;
    logic len_zero;
    logic data_done;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: src/frame_parser_sum_checksum.sv
// top level of the length-prefixed frame parser with additive checksum
// payload results pass the store read register, then the output register
// throughput: one received beat per cycle while parsing; each payload result is read from the payload store
// only after the previous one has been loaded into the output register
// input is held off while a frame's payload is being emitted
// reset: asynchronous active-low, parser idle, start byte register back to 0x7e
`timescale 1ns / 1ps

module frame_parser_sum_checksum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fps_pkg::ByteW-1:0]  cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [fps_pkg::ByteW-1:0]  s_axis_tdata,  // rx_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [fps_pkg::TdataW-1:0] m_axis_tdata,  // frame_type, frame_len, byte_index, data_byte
  output logic                       m_axis_tlast
);
  import fps_pkg::*;

  logic [ByteW-1:0] start_byte_q;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  fps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fps_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (s_axis_tdata),
    .start_byte_i (start_byte_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load_data || cmd.out_load_empty) |-> sts.out_free)
    else $error("output beat loaded while previous beat still held");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_issue |-> (!cmd.cap_data && !s_axis_tready))
    else $error("payload read while input beats are taken");

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load_data |-> $past(cmd.rd_issue) || $past(cmd.out_load_data) == 1'b0)
    else $error("payload beat loaded without a prior read");
`endif

endmodule

FILE: src/fps_ctrl.sv
// controller state machine of the frame parser
`timescale 1ns / 1ps

module fps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fps_pkg::ctrl_sts_t sts_i,
  output fps_pkg::ctrl_cmd_t cmd_o
);
  import fps_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StType   = 3'd1;
  localparam logic [2:0] StLenLo  = 3'd2;
  localparam logic [2:0] StLenHi  = 3'd3;
  localparam logic [2:0] StData   = 3'd4;
  localparam logic [2:0] StCheck  = 3'd5;
  localparam logic [2:0] StEmitRd = 3'd6;
  localparam logic [2:0] StEmitWr = 3'd7;

  logic [2:0] state_q, state_d;
  logic       fire;

  always_comb begin
    unique case (state_q)
      StIdle, StType, StLenLo, StLenHi, StData: in_ready_o = 1'b1;
      StCheck:                                  in_ready_o = sts_i.out_free;
      default:                                  in_ready_o = 1'b0;
    endcase
  end

  assign fire = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (fire && sts_i.start_match) begin
          cmd_o.cap_start = 1'b1;
          state_d         = StType;
        end
      end
      StType: begin
        if (fire) begin
          cmd_o.cap_type = 1'b1;
          state_d        = StLenLo;
        end
      end
      StLenLo: begin
        if (fire) begin
          cmd_o.cap_len_lo = 1'b1;
          state_d          = StLenHi;
        end
      end
      StLenHi: begin
        if (fire) begin
          if (sts_i.len_too_big) begin
            state_d = StIdle;
          end else begin
            cmd_o.cap_len_hi = 1'b1;
            state_d          = sts_i.in_len_zero ? StCheck : StData;
          end
        end
      end
      StData: begin
        if (fire) begin
          cmd_o.cap_data = 1'b1;
          if (sts_i.data_done) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (fire) begin
          if (!sts_i.sum_match) begin
            state_d = StIdle;
          end else if (sts_i.len_zero) begin
            cmd_o.out_load_empty = 1'b1;
            state_d              = StIdle;
          end else begin
            cmd_o.emit_start = 1'b1;
            state_d          = StEmitRd;
          end
        end
      end
      StEmitRd: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = StEmitWr;
      end
      StEmitWr: begin
        if (sts_i.out_free) begin
          cmd_o.out_load_data = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StIdle;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/fps_datapath.sv
// datapath of the frame parser: header fields, running sum, payload store, output beat
`timescale 1ns / 1ps

module fps_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fps_pkg::ByteW-1:0]  rx_byte_i,
  input  logic [fps_pkg::ByteW-1:0]  start_byte_i,
  input  fps_pkg::ctrl_cmd_t         cmd_i,
  output fps_pkg::ctrl_sts_t         sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [fps_pkg::TdataW-1:0] out_data_o,
  output logic                       out_last_o
);
  import fps_pkg::*;

  logic [ByteW-1:0] type_q;
  logic [ByteW-1:0] len_lo_q;
  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  cnt_q;
  logic [ByteW-1:0] sum_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [ByteW-1:0] rd_data_q;
  logic [ByteW-1:0] mem_q [StoreDepth];

  logic             valid_q;
  logic [ByteW-1:0] o_type_q;
  logic [LenW-1:0]  o_len_q;
  logic [AddrW-1:0] o_idx_q;
  logic [ByteW-1:0] o_data_q;
  logic             o_last_q;

  logic [LenW-1:0]  cnt_inc;
  logic [LenW-1:0]  rd_inc;

  assign cnt_inc = cnt_q + LenW'(1);
  assign rd_inc  = {1'b0, rd_idx_q} + LenW'(1);

  assign sts_o.start_match = (rx_byte_i == start_byte_i);
  assign sts_o.len_too_big = (rx_byte_i != '0) || (len_lo_q > {1'b0, MaxPayload});
  assign sts_o.in_len_zero = (rx_byte_i == '0) && (len_lo_q == '0);
  assign sts_o.len_zero    = (len_q == '0);
  assign sts_o.data_done   = (cnt_inc >= len_q);
  assign sts_o.sum_match   = (rx_byte_i == sum_q);
  assign sts_o.emit_last   = (rd_inc == len_q);
  assign sts_o.out_free    = !valid_q || out_ready_i;

  // header, count and running sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_start) begin
      sum_q <= rx_byte_i;
    end
    if (cmd_i.cap_type) begin
      type_q <= rx_byte_i;
      sum_q  <= sum_q + rx_byte_i;
    end
    if (cmd_i.cap_len_lo) begin
      len_lo_q <= rx_byte_i;
      sum_q    <= sum_q + rx_byte_i;
    end
    if (cmd_i.cap_len_hi) begin
      len_q <= len_lo_q[LenW-1:0];
      cnt_q <= '0;
      sum_q <= sum_q + rx_byte_i;
    end
    if (cmd_i.cap_data) begin
      cnt_q <= cnt_inc;
      sum_q <= sum_q + rx_byte_i;
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_data) begin
      mem_q[cnt_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= rd_inc[AddrW-1:0];
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load_data || cmd_i.out_load_empty) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_data) begin
      o_type_q <= type_q;
      o_len_q  <= len_q;
      o_idx_q  <= rd_idx_q;
      o_data_q <= rd_data_q;
      o_last_q <= sts_o.emit_last;
    end else if (cmd_i.out_load_empty) begin
      o_type_q <= type_q;
      o_len_q  <= '0;
      o_idx_q  <= '0;
      o_data_q <= '0;
      o_last_q <= 1'b1;
    end
  end

  assign out_valid_o = valid_q;
  assign out_last_o  = o_last_q;
  assign out_data_o  = {3'b000, o_data_q, o_idx_q, o_len_q, o_type_q};

endmodule
